### src/csq_pkg.sv
package csq_pkg;

    localparam int OPCODE_W = 3;
    localparam int STATUS_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W = 1;
    localparam int OUT_COUNT_W = 16;

    localparam logic [OPCODE_W-1:0] OP_WAIT     = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_TRY_WAIT = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_POST     = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_REMOVE   = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_READ     = 3'd4;

    localparam logic [STATUS_W-1:0] STS_GRANTED = 3'd0;
    localparam logic [STATUS_W-1:0] STS_REFUSED = 3'd1;
    localparam logic [STATUS_W-1:0] STS_QUEUED  = 3'd2;
    localparam logic [STATUS_W-1:0] STS_FULL    = 3'd3;
    localparam logic [STATUS_W-1:0] STS_DONE    = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_COUNT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_COUNT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN
    } t_state;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LATCH,
        CMD_GRANT,
        CMD_REFUSE,
        CMD_ENQUEUE,
        CMD_FULL,
        CMD_POST,
        CMD_DONE,
        CMD_SCAN_START,
        CMD_SCAN_STEP,
        CMD_SCAN_END
    } t_dp_cmd;

    typedef struct packed {
        logic count_zero;
        logic queue_full;
        logic queue_empty;
        logic scan_pend;
    } t_dp_status;

endpackage

### src/counting_semaphore_wait_queue.sv
// Channel   Ports                                              Direction  Handshake
// command   i_start, o_busy, i_opcode, i_task_id               in         start & !busy
// result    o_valid, o_status, o_count_now, o_woken_valid,     out        o_valid strobe,
//           o_woken_task                                                  one cycle
// config    i_cfg_we, i_cfg_idx, i_cfg_data                    in         i_cfg_we, no wait
//
// Wait, try wait, post, read count: latched in ST_IDLE, executed in ST_EXEC, then
// the result strobe. Remove: a compaction scan in ST_SCAN over the queued entries,
// one memory read per cycle (single read port, single write port on the id
// memory); with an empty queue it ends in ST_EXEC like the others.
// o_busy is low again in the strobe cycle, so the next command may go in then.
// Synchronous active-low reset: count 0, max count 1, queue empty.
// The result is held one cycle only; the receiver cannot stall it.
module counting_semaphore_wait_queue
    import csq_pkg::*;
#(
    parameter int QUEUE_DEPTH   = 16,
    parameter int TASK_ID_WIDTH = 8,
    parameter int COUNT_WIDTH   = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    output logic                     o_busy,
    input  logic [OPCODE_W-1:0]      i_opcode,
    input  logic [TASK_ID_WIDTH-1:0] i_task_id,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data,
    output logic                     o_valid,
    output logic [STATUS_W-1:0]      o_status,
    output logic [OUT_COUNT_W-1:0]   o_count_now,
    output logic                     o_woken_valid,
    output logic [TASK_ID_WIDTH-1:0] o_woken_task
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    csq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_opcode    (i_opcode),
        .i_dp_status (dp_status),
        .o_dp_cmd    (dp_cmd),
        .o_busy      (o_busy)
    );

    csq_dp #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .TASK_ID_WIDTH (TASK_ID_WIDTH),
        .COUNT_WIDTH   (COUNT_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_dp_cmd      (dp_cmd),
        .o_dp_status   (dp_status),
        .i_task_id     (i_task_id),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_count_now   (o_count_now),
        .o_woken_valid (o_woken_valid),
        .o_woken_task  (o_woken_task)
    );

endmodule

### src/csq_ctrl.sv
module csq_ctrl
    import csq_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [OPCODE_W-1:0] i_opcode,
    input  t_dp_status          i_dp_status,
    output t_dp_cmd             o_dp_cmd,
    output logic                o_busy
);

    t_state              r_state, n_state;
    logic [OPCODE_W-1:0] r_op, n_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_op <= n_op;
    end

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        o_dp_cmd = CMD_NONE;
        o_busy   = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_dp_cmd = CMD_LATCH;
                    n_op     = i_opcode;
                    n_state  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_IDLE;
                case (r_op)
                    OP_WAIT: begin
                        if (!i_dp_status.count_zero) begin
                            o_dp_cmd = CMD_GRANT;
                        end else if (i_dp_status.queue_full) begin
                            o_dp_cmd = CMD_FULL;
                        end else begin
                            o_dp_cmd = CMD_ENQUEUE;
                        end
                    end
                    OP_TRY_WAIT: begin
                        o_dp_cmd = i_dp_status.count_zero ? CMD_REFUSE : CMD_GRANT;
                    end
                    OP_POST: begin
                        o_dp_cmd = CMD_POST;
                    end
                    OP_REMOVE: begin
                        if (i_dp_status.queue_empty) begin
                            o_dp_cmd = CMD_DONE;
                        end else begin
                            o_dp_cmd = CMD_SCAN_START;
                            n_state  = ST_SCAN;
                        end
                    end
                    default: begin
                        // read count and unused opcodes
                        o_dp_cmd = CMD_DONE;
                    end
                endcase
            end
            ST_SCAN: begin
                if (i_dp_status.scan_pend) begin
                    o_dp_cmd = CMD_SCAN_STEP;
                end else begin
                    o_dp_cmd = CMD_SCAN_END;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

### src/csq_dp.sv
module csq_dp
    import csq_pkg::*;
#(
    parameter int QUEUE_DEPTH   = 16,
    parameter int TASK_ID_WIDTH = 8,
    parameter int COUNT_WIDTH   = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_dp_cmd,
    output t_dp_status               o_dp_status,
    input  logic [TASK_ID_WIDTH-1:0] i_task_id,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data,
    output logic                     o_valid,
    output logic [STATUS_W-1:0]      o_status,
    output logic [OUT_COUNT_W-1:0]   o_count_now,
    output logic                     o_woken_valid,
    output logic [TASK_ID_WIDTH-1:0] o_woken_task
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int TOT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int CMP_W = (COUNT_WIDTH > CFG_DATA_W) ? COUNT_WIDTH : CFG_DATA_W;

    // circular buffer of waiting task ids, head is the oldest
    logic [TASK_ID_WIDTH-1:0] mem [QUEUE_DEPTH];

    logic [COUNT_WIDTH-1:0]   r_count, n_count;
    logic [CFG_DATA_W-1:0]    r_max, n_max;
    logic [TOT_W-1:0]         r_total, n_total;
    logic [PTR_W-1:0]         r_head, n_head;
    logic [PTR_W-1:0]         r_tail, n_tail;
    logic [TASK_ID_WIDTH-1:0] r_tid, n_tid;
    logic [TASK_ID_WIDTH-1:0] r_rd_data;
    logic [PTR_W-1:0]         r_rd_ptr, n_rd_ptr;
    logic [TOT_W-1:0]         r_rd_cnt, n_rd_cnt;
    logic                     r_pend, n_pend;
    logic [PTR_W-1:0]         r_wr_ptr, n_wr_ptr;
    logic [TOT_W-1:0]         r_keep, n_keep;
    logic                     r_valid, n_valid;
    logic [STATUS_W-1:0]      r_status, n_status;
    logic [OUT_COUNT_W-1:0]   r_count_out, n_count_out;
    logic                     r_woken_valid, n_woken_valid;
    logic [TASK_ID_WIDTH-1:0] r_woken_task, n_woken_task;

    logic                     mem_we;
    logic [PTR_W-1:0]         mem_waddr;
    logic [TASK_ID_WIDTH-1:0] mem_wdata;
    logic [PTR_W-1:0]         mem_raddr;
    logic                     can_inc;
    logic [CMP_W-1:0]         cnt_ext;
    logic [CMP_W-1:0]         cfg_ext;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
            return '0;
        end else begin
            return p + 1'b1;
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count       <= '0;
            r_max         <= CFG_DATA_W'(1);
            r_total       <= '0;
            r_head        <= '0;
            r_tail        <= '0;
            r_pend        <= 1'b0;
            r_valid       <= 1'b0;
        end else begin
            r_count       <= n_count;
            r_max         <= n_max;
            r_total       <= n_total;
            r_head        <= n_head;
            r_tail        <= n_tail;
            r_pend        <= n_pend;
            r_valid       <= n_valid;
        end
        r_tid         <= n_tid;
        r_rd_ptr      <= n_rd_ptr;
        r_rd_cnt      <= n_rd_cnt;
        r_wr_ptr      <= n_wr_ptr;
        r_keep        <= n_keep;
        r_status      <= n_status;
        r_count_out   <= n_count_out;
        r_woken_valid <= n_woken_valid;
        r_woken_task  <= n_woken_task;
    end

    assign can_inc = (CMP_W'(r_count) < CMP_W'(r_max)) && (r_count != '1);
    assign cfg_ext = CMP_W'(i_cfg_data);

    always_comb begin
        n_count       = r_count;
        n_max         = r_max;
        n_total       = r_total;
        n_head        = r_head;
        n_tail        = r_tail;
        n_tid         = r_tid;
        n_rd_ptr      = r_rd_ptr;
        n_rd_cnt      = r_rd_cnt;
        n_pend        = r_pend;
        n_wr_ptr      = r_wr_ptr;
        n_keep        = r_keep;
        n_valid       = 1'b0;
        n_status      = r_status;
        n_woken_valid = 1'b0;
        n_woken_task  = '0;
        mem_we        = 1'b0;
        mem_waddr     = r_tail;
        mem_wdata     = r_tid;
        // outside a scan the read port keeps the head entry ready for post
        mem_raddr     = (i_dp_cmd == CMD_SCAN_STEP) ? r_rd_ptr : r_head;

        case (i_dp_cmd)
            CMD_LATCH: begin
                n_tid = i_task_id;
            end
            CMD_GRANT: begin
                n_count  = r_count - 1'b1;
                n_valid  = 1'b1;
                n_status = STS_GRANTED;
            end
            CMD_REFUSE: begin
                n_valid  = 1'b1;
                n_status = STS_REFUSED;
            end
            CMD_ENQUEUE: begin
                mem_we   = 1'b1;
                n_tail   = ptr_inc(r_tail);
                n_total  = r_total + 1'b1;
                n_valid  = 1'b1;
                n_status = STS_QUEUED;
            end
            CMD_FULL: begin
                n_valid  = 1'b1;
                n_status = STS_FULL;
            end
            CMD_POST: begin
                if (can_inc) begin
                    n_count = r_count + 1'b1;
                end
                if (r_total != '0) begin
                    n_woken_valid = 1'b1;
                    n_woken_task  = r_rd_data;
                    n_head        = ptr_inc(r_head);
                    n_total       = r_total - 1'b1;
                end
                n_valid  = 1'b1;
                n_status = STS_DONE;
            end
            CMD_DONE: begin
                n_valid  = 1'b1;
                n_status = STS_DONE;
            end
            CMD_SCAN_START: begin
                // head entry is already being read this cycle
                n_rd_ptr = ptr_inc(r_head);
                n_rd_cnt = TOT_W'(1);
                n_pend   = 1'b1;
                n_wr_ptr = r_head;
                n_keep   = '0;
            end
            CMD_SCAN_STEP: begin
                // write side trails the read side, survivors slide toward head
                if (r_pend && (r_rd_data != r_tid)) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_wr_ptr;
                    mem_wdata = r_rd_data;
                    n_wr_ptr  = ptr_inc(r_wr_ptr);
                    n_keep    = r_keep + 1'b1;
                end
                n_pend = (r_rd_cnt < r_total);
                if (r_rd_cnt < r_total) begin
                    n_rd_ptr = ptr_inc(r_rd_ptr);
                    n_rd_cnt = r_rd_cnt + 1'b1;
                end
            end
            CMD_SCAN_END: begin
                n_total  = r_keep;
                n_tail   = r_wr_ptr;
                n_valid  = 1'b1;
                n_status = STS_DONE;
            end
            default: begin
            end
        endcase

        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAX_COUNT:  n_max = i_cfg_data;
                CFG_INIT_COUNT: n_count = cfg_ext[COUNT_WIDTH-1:0];
                default: begin
                end
            endcase
        end

        cnt_ext     = CMP_W'(n_count);
        n_count_out = cnt_ext[OUT_COUNT_W-1:0];
    end

    assign o_dp_status.count_zero  = (r_count == '0);
    assign o_dp_status.queue_full  = (r_total == TOT_W'(QUEUE_DEPTH));
    assign o_dp_status.queue_empty = (r_total == '0);
    assign o_dp_status.scan_pend   = r_pend;

    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_count_now   = r_count_out;
    assign o_woken_valid = r_woken_valid;
    assign o_woken_task  = r_woken_task;

endmodule
